### sv/utpm_pkg.sv
`default_nettype none

package utpm_pkg;

    localparam int MAX_DIM_DEF   = 64;
    localparam int DATA_BITS_DEF = 16;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W    = 12;
    localparam int IDX_W     = 6;
    localparam int VALUE_W   = 16;
    localparam int SUM_W     = 40;
    localparam int OP_W      = 2;

    localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_K = 2'd2;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

`default_nettype wire

### sv/upper_triangular_packed_matmul.sv
`default_nettype none

// Returns single elements of C = A * B, where A is dense (rows_m by depth_k,
// row-major) and B is upper triangular (depth_k by cols_n, packed row by row).
// A request is taken when start is high and busy is low. Loads of A or packed
// B give no result. A query whose row or column lies outside the configured
// sizes gives its result in the next cycle. Any other query reads one A
// and one B element per cycle from the two stores into a single
// multiply-accumulate unit; the addresses, store reads, product and result
// are each registered. The block stays busy until the sum is finished. The
// result is shown with o_valid for exactly one cycle and cannot be held off,
// so the receiver must take it then. Reading an element that was never
// loaded gives an undefined sum. Configuration may only be written while
// the block is idle.
module upper_triangular_packed_matmul #(
    parameter int MAX_DIM   = utpm_pkg::MAX_DIM_DEF,
    parameter int DATA_BITS = utpm_pkg::DATA_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [utpm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [utpm_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire                             start,
    output logic                            busy,
    input  wire [utpm_pkg::OP_W-1:0]        i_opcode,
    input  wire [utpm_pkg::ADDR_W-1:0]      i_address,
    input  wire signed [utpm_pkg::VALUE_W-1:0] i_value,
    input  wire [utpm_pkg::IDX_W-1:0]       i_row,
    input  wire [utpm_pkg::IDX_W-1:0]       i_col,
    output logic                            o_valid,
    output logic [utpm_pkg::IDX_W-1:0]      o_out_row,
    output logic [utpm_pkg::IDX_W-1:0]      o_out_col,
    output logic signed [utpm_pkg::SUM_W-1:0] o_sum,
    output logic                            o_in_range
);
    import utpm_pkg::*;

    localparam int ELEM_W = (DATA_BITS < VALUE_W) ? DATA_BITS : VALUE_W;

    logic               accept;
    logic               query;
    logic               we_a;
    logic               we_b;
    logic               miss;
    logic               fin;
    t_mac_ctl           mac_ctl;
    logic [ADDR_W-1:0]  a_addr;
    logic [ADDR_W-1:0]  b_addr;
    logic [ELEM_W-1:0]  a_data;
    logic [ELEM_W-1:0]  b_data;
    logic [SUM_W-1:0]   mac_sum;
    logic [IDX_W-1:0]   r_q_row;
    logic [IDX_W-1:0]   r_q_col;

    assign accept = start && !busy;
    assign query  = accept && (i_opcode == OP_QUERY);
    assign we_a   = accept && (i_opcode == OP_LOAD_A);
    assign we_b   = accept && (i_opcode == OP_LOAD_B);

    utpm_store #(.ELEM_W(ELEM_W)) u_a_store (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (i_address),
        .i_wdata (i_value[ELEM_W-1:0]),
        .i_raddr (a_addr),
        .o_rdata (a_data)
    );

    utpm_store #(.ELEM_W(ELEM_W)) u_b_store (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (i_address),
        .i_wdata (i_value[ELEM_W-1:0]),
        .i_raddr (b_addr),
        .o_rdata (b_data)
    );

    utpm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_query    (query),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_fin      (fin),
        .o_busy     (busy),
        .o_miss     (miss),
        .o_ctl      (mac_ctl),
        .o_a_addr   (a_addr),
        .o_b_addr   (b_addr)
    );

    utpm_mac #(.ELEM_W(ELEM_W)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (a_data),
        .i_b     (b_data),
        .o_fin   (fin),
        .o_sum   (mac_sum)
    );

    always_ff @(posedge i_clk) begin
        if (query) begin
            r_q_row <= i_row;
            r_q_col <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= miss || fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (miss) begin
            o_out_row  <= i_row;
            o_out_col  <= i_col;
            o_sum      <= '0;
            o_in_range <= 1'b0;
        end else if (fin) begin
            o_out_row  <= r_q_row;
            o_out_col  <= r_q_col;
            o_sum      <= mac_sum;
            o_in_range <= 1'b1;
        end
    end

endmodule

`default_nettype wire

### sv/utpm_store.sv
`default_nettype none

module utpm_store #(
    parameter int ELEM_W = 16
) (
    input  wire                        i_clk,
    input  wire                        i_we,
    input  wire [utpm_pkg::ADDR_W-1:0] i_waddr,
    input  wire [ELEM_W-1:0]           i_wdata,
    input  wire [utpm_pkg::ADDR_W-1:0] i_raddr,
    output logic [ELEM_W-1:0]          o_rdata
);
    import utpm_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [ELEM_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/utpm_mac.sv
`default_nettype none

module utpm_mac #(
    parameter int ELEM_W = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  utpm_pkg::t_mac_ctl        i_ctl,
    input  wire [ELEM_W-1:0]          i_a,
    input  wire [ELEM_W-1:0]          i_b,
    output logic                      o_fin,
    output logic [utpm_pkg::SUM_W-1:0] o_sum
);
    import utpm_pkg::*;

    localparam int PROD_W = 2 * ELEM_W;

    t_mac_ctl                   r_ctl_d1;
    t_mac_ctl                   r_ctl_d2;
    logic signed [PROD_W-1:0]   r_prod;
    logic [SUM_W-1:0]           r_acc;
    logic [SUM_W-1:0]           prod_ext;
    logic [SUM_W-1:0]           n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_d1 <= '0;
            r_ctl_d2 <= '0;
        end else begin
            r_ctl_d1 <= i_ctl;
            r_ctl_d2 <= r_ctl_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_a) * $signed(i_b);
    end

    assign prod_ext = SUM_W'(r_prod);
    assign n_acc    = r_ctl_d2.first ? prod_ext : r_acc + prod_ext;

    always_ff @(posedge i_clk) begin
        if (r_ctl_d2.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_fin = r_ctl_d2.valid & r_ctl_d2.last;
    assign o_sum = n_acc;

    a_first_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl_d2.last && !r_ctl_d2.valid |-> !o_fin)
        else $error("finish flagged without a valid term");

    a_ctl_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.valid && i_ctl.last |=> ##1 o_fin)
        else $error("finish did not follow the last term by two cycles");

    a_first_after_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ctl_d1.valid && i_ctl.valid |-> i_ctl.first)
        else $error("a new sum did not start with its first term");

endmodule

`default_nettype wire

### sv/utpm_ctrl.sv
`default_nettype none

module utpm_ctrl #(
    parameter int MAX_DIM = 64
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [utpm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [utpm_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire                            i_query,
    input  wire [utpm_pkg::IDX_W-1:0]      i_row,
    input  wire [utpm_pkg::IDX_W-1:0]      i_col,
    input  wire                            i_fin,
    output logic                           o_busy,
    output logic                           o_miss,
    output utpm_pkg::t_mac_ctl             o_ctl,
    output logic [utpm_pkg::ADDR_W-1:0]    o_a_addr,
    output logic [utpm_pkg::ADDR_W-1:0]    o_b_addr
);
    import utpm_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam logic [8:0] MAX_LIM = 9'(MAX_DIM);

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CFG_W-1:0]   r_rows;
    logic [CFG_W-1:0]   r_cols;
    logic [CFG_W-1:0]   r_depth;
    logic [CFG_W-1:0]   cfg_clamped;
    logic [IDX_W-1:0]   r_k;
    logic [IDX_W-1:0]   n_k;
    logic [IDX_W-1:0]   r_last;
    logic [IDX_W-1:0]   n_last;
    logic [ADDR_W-1:0]  r_a_ptr;
    logic [ADDR_W-1:0]  n_a_ptr;
    logic [ADDR_W-1:0]  r_b_ptr;
    logic [ADDR_W-1:0]  n_b_ptr;
    logic [CFG_W-1:0]   depth_m1;
    logic               in_range;

    always_comb begin
        cfg_clamped = i_cfg_data;
        if (i_cfg_data == '0) begin
            cfg_clamped = CFG_W'(1);
        end else if ({2'b00, i_cfg_data} > MAX_LIM) begin
            cfg_clamped = CFG_W'(MAX_DIM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= DIM_RESET;
            r_cols  <= DIM_RESET;
            r_depth <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROWS_M:  r_rows  <= cfg_clamped;
                REG_COLS_N:  r_cols  <= cfg_clamped;
                REG_DEPTH_K: r_depth <= cfg_clamped;
                default: ;
            endcase
        end
    end

    assign in_range = ({1'b0, i_row} < r_rows) && ({1'b0, i_col} < r_cols);
    assign depth_m1 = r_depth - CFG_W'(1);
    assign o_miss   = i_query && !in_range;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_last  = r_last;
        n_a_ptr = r_a_ptr;
        n_b_ptr = r_b_ptr;
        case (r_state)
            ST_IDLE: begin
                if (i_query && in_range) begin
                    n_state = ST_RUN;
                    n_k     = '0;
                    n_last  = ({1'b0, i_col} < depth_m1) ? i_col : depth_m1[IDX_W-1:0];
                    n_a_ptr = ADDR_W'(i_row * r_depth);
                    n_b_ptr = ADDR_W'(i_col);
                end
            end
            ST_RUN: begin
                n_k     = r_k + IDX_W'(1);
                n_a_ptr = r_a_ptr + ADDR_W'(1);
                n_b_ptr = r_b_ptr + ADDR_W'(r_cols) - ADDR_W'(r_k) - ADDR_W'(1);
                if (r_k == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_fin) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_last  <= n_last;
        r_a_ptr <= n_a_ptr;
        r_b_ptr <= n_b_ptr;
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_ctl.valid = (r_state == ST_RUN);
    assign o_ctl.first = (r_k == '0);
    assign o_ctl.last  = (r_k == r_last);
    assign o_a_addr    = r_a_ptr;
    assign o_b_addr    = r_b_ptr;

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_k <= r_last)
        else $error("inner index ran past its last term");

    a_run_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN && r_k == r_last |=> r_state == ST_DRAIN)
        else $error("sequencer did not stop issuing after the last term");

    a_fin_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fin |-> r_state == ST_DRAIN)
        else $error("sum finished outside the drain phase");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_query && in_range && r_state == ST_IDLE |=> o_busy)
        else $error("in-range query did not make the block busy");

endmodule

`default_nettype wire

### tb/matmul_result_checker.sv
module matmul_result_checker #(
    parameter int MAX_DIM   = utpm_pkg::MAX_DIM_DEF,
    parameter int DATA_BITS = utpm_pkg::DATA_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [utpm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [utpm_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  logic [utpm_pkg::OP_W-1:0]            i_opcode,
    input  logic [utpm_pkg::ADDR_W-1:0]          i_address,
    input  logic [utpm_pkg::VALUE_W-1:0]         i_value,
    input  logic [utpm_pkg::IDX_W-1:0]           i_row,
    input  logic [utpm_pkg::IDX_W-1:0]           i_col,
    input  logic                                 i_valid,
    input  logic [utpm_pkg::IDX_W-1:0]           i_out_row,
    input  logic [utpm_pkg::IDX_W-1:0]           i_out_col,
    input  logic [utpm_pkg::SUM_W-1:0]           i_sum,
    input  logic                                 i_in_range,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import utpm_pkg::*;

    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int STORE_MASK  = STORE_DEPTH - 1;

    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [SUM_W-1:0] sum;
        logic             in_range;
    } t_element;

    logic signed [VALUE_W-1:0] a_mem [STORE_DEPTH];
    logic signed [VALUE_W-1:0] b_mem [STORE_DEPTH];
    int unsigned rows_m = DIM_RESET;
    int unsigned cols_n = DIM_RESET;
    int unsigned depth_k = DIM_RESET;
    t_element expected_elements [$];
    int fail_count = 0;
    int checked = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
    end

    function automatic int unsigned fit_dim(logic [CFG_W-1:0] d);
        if (d == 0) begin
            return 1;
        end
        if (d > MAX_DIM) begin
            return MAX_DIM;
        end
        return d;
    endfunction

    function automatic logic signed [VALUE_W-1:0] narrow(logic [VALUE_W-1:0] v);
        int bits;
        int u;
        bits = (DATA_BITS < VALUE_W) ? DATA_BITS : VALUE_W;
        u = v & ((1 << bits) - 1);
        if (((u >> (bits - 1)) & 1) == 1) begin
            u -= 1 << bits;
        end
        return u[VALUE_W-1:0];
    endfunction

    function automatic t_element product_element(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
        t_element e;
        int unsigned top_k;
        int unsigned a_addr;
        int unsigned b_addr;
        longint acc;
        acc = 0;
        e.row = row;
        e.col = col;
        e.in_range = (row < rows_m) && (col < cols_n);
        if (e.in_range) begin
            top_k = (col < depth_k - 1) ? col : depth_k - 1;
            for (int unsigned kk = 0; kk <= top_k; kk++) begin
                a_addr = (row * depth_k + kk) & STORE_MASK;
                b_addr = (kk * cols_n - (kk * (kk > 0 ? kk - 1 : 0)) / 2 + col - kk)
                         & STORE_MASK;
                acc += longint'(a_mem[a_addr]) * longint'(b_mem[b_addr]);
            end
        end
        e.sum = e.in_range ? acc[SUM_W-1:0] : '0;
        return e;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_element want;
        if (!i_rst_n) begin
            rows_m = DIM_RESET;
            cols_n = DIM_RESET;
            depth_k = DIM_RESET;
        end else begin
            // Results are retired before new requests so that a result leaving
            // at the same edge as a new acceptance pairs with the older request.
            if (i_valid === 1'b1) begin
                if (expected_elements.size() == 0) begin
                    report_mismatch($sformatf("result (%0d,%0d) with no query waiting",
                                              i_out_row, i_out_col));
                end else begin
                    want = expected_elements.pop_front();
                    checked++;
                    if (i_out_row !== want.row) begin
                        report_mismatch($sformatf("out_row %0d, expected %0d",
                                                  i_out_row, want.row));
                    end
                    if (i_out_col !== want.col) begin
                        report_mismatch($sformatf("out_col %0d, expected %0d",
                                                  i_out_col, want.col));
                    end
                    if (i_sum !== want.sum) begin
                        report_mismatch($sformatf("sum %h, expected %h at (%0d,%0d)",
                                                  i_sum, want.sum, want.row, want.col));
                    end
                    if (i_in_range !== want.in_range) begin
                        report_mismatch($sformatf("in_range %b, expected %b at (%0d,%0d)",
                                                  i_in_range, want.in_range,
                                                  want.row, want.col));
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                case (i_opcode)
                    OP_LOAD_A: begin
                        a_mem[i_address] = narrow(i_value);
                    end
                    OP_LOAD_B: begin
                        b_mem[i_address] = narrow(i_value);
                    end
                    OP_QUERY: begin
                        expected_elements.push_back(product_element(i_row, i_col));
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_idx)
                    REG_ROWS_M: begin
                        rows_m = fit_dim(i_cfg_data);
                    end
                    REG_COLS_N: begin
                        cols_n = fit_dim(i_cfg_data);
                    end
                    REG_DEPTH_K: begin
                        depth_k = fit_dim(i_cfg_data);
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending <= expected_elements.size();
        o_checked <= checked;
    end

endmodule

### tb/upper_triangular_packed_matmul_tb.sv
module upper_triangular_packed_matmul_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import utpm_pkg::*;

    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE   = 2'd3;
    localparam int                   ITEMS      = 1800;
    localparam int                   PHASES     = 8;
    localparam int                   CYCLE_LIMIT = 1000000;

    localparam logic [CFG_W-1:0] PHASE_M [PHASES] = '{7'd64, 7'd1, 7'd0, 7'd12,
                                                     7'd64, 7'd127, 7'd5, 7'd64};
    localparam logic [CFG_W-1:0] PHASE_N [PHASES] = '{7'd64, 7'd1, 7'd127, 7'd9,
                                                     7'd1, 7'd64, 7'd64, 7'd64};
    localparam logic [CFG_W-1:0] PHASE_K [PHASES] = '{7'd64, 7'd1, 7'd5, 7'd20,
                                                     7'd64, 7'd1, 7'd64, 7'd64};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [OP_W-1:0]      i_opcode = '0;
    logic [ADDR_W-1:0]    i_address = '0;
    logic [VALUE_W-1:0]   i_value = '0;
    logic [IDX_W-1:0]     i_row = '0;
    logic [IDX_W-1:0]     i_col = '0;
    logic                 o_valid;
    logic [IDX_W-1:0]     o_out_row;
    logic [IDX_W-1:0]     o_out_col;
    logic [SUM_W-1:0]     o_sum;
    logic                 o_in_range;

    int  fail_count;
    int  pending;
    int  checked;
    int  items_sent = 0;
    int  queries_sent = 0;
    int  cycles = 0;
    bit  steady = 1'b0;
    int  dims_m = 64;
    int  dims_n = 64;
    int  dims_k = 64;
    bit  a_written [1 << ADDR_W];
    bit  b_written [1 << ADDR_W];

    upper_triangular_packed_matmul dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_address  (i_address),
        .i_value    (i_value),
        .i_row      (i_row),
        .i_col      (i_col),
        .o_valid    (o_valid),
        .o_out_row  (o_out_row),
        .o_out_col  (o_out_col),
        .o_sum      (o_sum),
        .o_in_range (o_in_range)
    );

    matmul_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_start      (start),
        .i_busy       (busy),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_value      (i_value),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_valid      (o_valid),
        .i_out_row    (o_out_row),
        .i_out_col    (o_out_col),
        .i_sum        (o_sum),
        .i_in_range   (o_in_range),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Run timed out with %0d results still awaited.", pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int fit_size(logic [CFG_W-1:0] d);
        if (d == 0) begin
            return 1;
        end
        return (d > 64) ? 64 : d;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0) begin
            return 16'h8000;
        end
        if (pick == 1) begin
            return 16'h7fff;
        end
        return $urandom;
    endfunction

    task automatic send_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                logic [VALUE_W-1:0] val, logic [IDX_W-1:0] r,
                                logic [IDX_W-1:0] c);
        if (!steady && $urandom_range(99) < 21) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(2)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_opcode <= op;
        i_address <= addr;
        i_value <= val;
        i_row <= r;
        i_col <= c;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        if (op == OP_LOAD_A) begin
            a_written[addr] = 1'b1;
        end else if (op == OP_LOAD_B) begin
            b_written[addr] = 1'b1;
        end
        if (op != OP_UNUSED) begin
            items_sent++;
        end
    endtask

    // Loads any A or packed B element the query will read that has not been
    // written since reset, then issues the query itself.
    task automatic query_element(int r, int c);
        int top_k;
        int aa;
        int ba;
        if (r < dims_m && c < dims_n) begin
            top_k = (c < dims_k - 1) ? c : dims_k - 1;
            for (int kk = 0; kk <= top_k; kk++) begin
                aa = (r * dims_k + kk) & 12'hfff;
                ba = (kk * dims_n - (kk * (kk > 0 ? kk - 1 : 0)) / 2 + c - kk) & 12'hfff;
                if (!a_written[aa]) begin
                    send_request(OP_LOAD_A, aa, rand_value(), $urandom, $urandom);
                end
                if (!b_written[ba]) begin
                    send_request(OP_LOAD_B, ba, rand_value(), $urandom, $urandom);
                end
            end
        end
        send_request(OP_QUERY, $urandom, $urandom, r, c);
        queries_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_size_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure_sizes(logic [CFG_W-1:0] m, logic [CFG_W-1:0] n,
                                   logic [CFG_W-1:0] k);
        drain();
        write_size_reg(REG_ROWS_M, m);
        write_size_reg(REG_COLS_N, n);
        write_size_reg(REG_DEPTH_K, k);
        write_size_reg(REG_NONE, $urandom);
        dims_m = fit_size(m);
        dims_n = fit_size(n);
        dims_k = fit_size(k);
    endtask

    task automatic random_request();
        int pick;
        int span;
        pick = $urandom_range(99);
        if (pick < 5) begin
            send_request(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 25) begin
            span = dims_m * dims_k;
            send_request(OP_LOAD_A, $urandom_range(1) ? $urandom : $urandom_range(span - 1),
                         rand_value(), $urandom, $urandom);
        end else if (pick < 45) begin
            span = dims_k * dims_n;
            send_request(OP_LOAD_B, $urandom_range(1) ? $urandom : $urandom_range(span - 1),
                         rand_value(), $urandom, $urandom);
        end else if (pick < 55) begin
            query_element($urandom_range(63), $urandom_range(63));
        end else begin
            query_element($urandom_range(dims_m - 1), $urandom_range(dims_n - 1));
        end
    endtask

    initial begin
        int goal;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: clamped register writes, store address extremes, the
        // largest products, an out-of-range query and an ignored opcode.
        configure_sizes(7'd0, 7'd127, 7'd2);
        send_request(OP_LOAD_A, 12'hfff, 16'h7fff, 6'd0, 6'd0);
        send_request(OP_LOAD_B, 12'hfff, 16'h8000, 6'd63, 6'd63);
        send_request(OP_LOAD_A, 12'd0, 16'h8000, 6'd0, 6'd0);
        send_request(OP_LOAD_B, 12'd0, 16'h8000, 6'd0, 6'd0);
        query_element(0, 0);
        send_request(OP_LOAD_A, 12'd1, 16'h7fff, 6'd0, 6'd0);
        query_element(0, 63);
        query_element(0, 1);
        query_element(63, 5);
        send_request(OP_UNUSED, 12'hfff, 16'hffff, 6'd63, 6'd63);
        query_element(0, 0);

        for (int p = 0; p < PHASES; p++) begin
            configure_sizes(PHASE_M[p], PHASE_N[p], PHASE_K[p]);
            steady = (p == 3);
            goal = items_sent + ITEMS / PHASES;
            while (items_sent < goal) begin
                random_request();
            end
        end
        steady = 1'b0;

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (80) @(negedge i_clk);
        $display("Sent %0d load and query requests (%0d queries) over %0d size settings;",
                 items_sent, queries_sent, PHASES + 1);
        $display("%0d results were compared field by field.", checked);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
